@@ rtl/rbrp_pkg.sv @@
`timescale 1ns / 1ps

package rbrp_pkg;

    // Block layout
    localparam int HEADER_LEN = 9;
    localparam int SAMPLE_LEN = 5;
    localparam int POS_W      = 6;
    localparam int IDX_W      = 4;
    localparam int KCNT_W     = 3;

    // Record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Distance scaling: x / 39 == (x * DIST_RECIP) >> DIST_SHIFT for x < 2**28
    localparam int             DIST10_W   = 28;
    localparam int             RECIP_W    = 29;
    localparam int             DIST_SHIFT = 34;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 29'd440509467;

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    localparam int OUT_TDATA_W = 120;

    // One sample together with the header it belongs to
    typedef struct packed {
        logic [HEADER_LEN-1:0][7:0] hdr;
        logic [3:0][7:0]            smp;
        logic [7:0]                 last;
        logic [IDX_W-1:0]           index;
    } rbrp_rec_t;

    typedef struct packed {
        logic      valid;
        rbrp_rec_t rec;
    } rbrp_push_t;

    typedef struct packed {
        logic full;
        logic valid;
    } rbrp_qstat_t;

    // Two-digit BCD, digits above nine taken as is
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'd0, v[7:4]};
        return tens * 8'd10 + {4'd0, v[3:0]};
    endfunction

endpackage

@@ rtl/rbrp_front.sv @@
`timescale 1ns / 1ps

module rbrp_front #(
    parameter int SAMPLES_PER_BLOCK = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  rbrp_pkg::rbrp_qstat_t qstat,
    output rbrp_pkg::rbrp_push_t  push
);
    import rbrp_pkg::*;

    localparam int BLOCK_LEN = HEADER_LEN + SAMPLE_LEN * SAMPLES_PER_BLOCK;
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(BLOCK_LEN - 1);
    localparam logic [POS_W-1:0]  POS_HDR  = POS_W'(HEADER_LEN);
    localparam logic [KCNT_W-1:0] K_LAST   = KCNT_W'(SAMPLE_LEN - 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [KCNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic              ended_reg, ended_next;
    logic [HEADER_LEN-1:0][7:0] hdr_reg;
    logic [3:0][7:0]            smp_reg;

    logic beat;
    logic in_header;
    logic sample_end;
    logic sample_zero;

    assign s_tready    = !qstat.full;
    assign beat        = s_tvalid && s_tready;
    assign in_header   = pos_reg < POS_HDR;
    assign sample_end  = !in_header && (k_reg == K_LAST);
    assign sample_zero = ((smp_reg[0] | smp_reg[1] | smp_reg[2] | smp_reg[3] | s_tdata) == 8'd0);

    // Position, sample counters and end-of-block flag
    always_comb begin
        pos_next   = pos_reg;
        k_next     = k_reg;
        index_next = index_reg;
        ended_next = ended_reg;
        if (beat) begin
            if (!in_header) begin
                if (sample_end) begin
                    k_next     = '0;
                    index_next = index_reg + 1'b1;
                    if (!ended_reg && sample_zero) begin
                        ended_next = 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            if (pos_reg == POS_LAST) begin
                pos_next   = '0;
                k_next     = '0;
                index_next = '0;
                ended_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            k_reg     <= '0;
            index_reg <= '0;
            ended_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            k_reg     <= k_next;
            index_reg <= index_next;
            ended_reg <= ended_next;
        end
    end

    // Header and sample byte capture
    always_ff @(posedge aclk) begin
        if (beat) begin
            if (in_header) begin
                hdr_reg[pos_reg[3:0]] <= s_tdata;
            end else if (!sample_end) begin
                smp_reg[k_reg[1:0]] <= s_tdata;
            end
        end
    end

    // Record for every non-zero sample of a live block
    assign push.valid     = beat && sample_end && !ended_reg && !sample_zero;
    assign push.rec.hdr   = hdr_reg;
    assign push.rec.smp   = smp_reg;
    assign push.rec.last  = s_tdata;
    assign push.rec.index = index_reg;

endmodule

@@ rtl/rbrp_queue.sv @@
`timescale 1ns / 1ps

module rbrp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rbrp_pkg::rbrp_push_t  push,
    input  logic                  pop,
    output rbrp_pkg::rbrp_rec_t   pop_rec,
    output rbrp_pkg::rbrp_qstat_t qstat
);
    import rbrp_pkg::*;

    rbrp_rec_t mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_push;
    logic do_pop;

    assign qstat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.valid = (cnt_reg != '0);
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && qstat.valid;
    assign pop_rec     = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

@@ rtl/rbrp_back.sv @@
`timescale 1ns / 1ps

module rbrp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbrp_pkg::rbrp_qstat_t          qstat,
    input  rbrp_pkg::rbrp_rec_t            rec,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbrp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rbrp_pkg::*;

    // Decode stage
    logic                s1_valid_reg, s1_valid_next;
    logic [5:0]          s1_day_reg;
    logic [4:0]          s1_month_reg;
    logic [5:0]          s1_hour_reg;
    logic [7:0]          s1_min_reg;
    logic [7:0]          s1_sec_reg;
    logic [DIST10_W-1:0] s1_dist10_reg;
    logic [7:0]          s1_temp_reg;
    logic [7:0]          s1_ivl_reg;
    logic [IDX_W-1:0]    s1_index_reg;
    logic [11:0]         s1_power_reg;
    logic [9:0]          s1_speed_reg;
    logic [7:0]          s1_cad_reg;
    logic [7:0]          s1_hr_reg;
    logic [1:0]          s1_mark_reg;

    // Output stage
    logic        out_valid_reg, out_valid_next;
    logic [17:0] out_secs_reg;
    logic [22:0] out_dist_reg;
    logic [10:0] out_offset_reg;
    logic [5:0]  out_day_reg;
    logic [4:0]  out_month_reg;
    logic [7:0]  out_temp_reg;
    logic [7:0]  out_ivl_reg;
    logic [11:0] out_power_reg;
    logic [9:0]  out_speed_reg;
    logic [7:0]  out_cad_reg;
    logic [7:0]  out_hr_reg;
    logic [1:0]  out_mark_reg;

    logic        adv_out;
    logic        s1_ready;
    logic [3:0]  ivl_raw;
    logic [7:0]  ivl;
    logic [23:0] raw_dist;
    logic [7:0]  day_full;
    logic [7:0]  month_full;
    logic [7:0]  hour_full;
    logic [DIST10_W+RECIP_W-1:0] dist_prod;
    logic [17:0] secs;
    logic [10:0] offset;

    assign adv_out  = !out_valid_reg || m_tready;
    assign s1_ready = !s1_valid_reg || adv_out;
    assign pop      = s1_ready && qstat.valid;

    // Header and sample decode
    assign ivl_raw    = {rec.hdr[0][6], rec.hdr[1][7:5]};
    assign ivl        = rec.hdr[2][6] ? {4'd0, ivl_raw} : {4'd0, ivl_raw} * 8'd10;
    assign raw_dist   = {rec.hdr[5], rec.hdr[6], rec.hdr[7]};
    assign day_full   = bcd_value({2'd0, rec.hdr[0][5:0]});
    assign month_full = bcd_value({3'd0, rec.hdr[1][4:0]});
    assign hour_full  = bcd_value({2'd0, rec.hdr[2][5:0]});

    assign s1_valid_next = s1_ready ? qstat.valid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_day_reg    <= day_full[5:0];
            s1_month_reg  <= month_full[4:0];
            s1_hour_reg   <= hour_full[5:0];
            s1_min_reg    <= bcd_value(rec.hdr[3]);
            s1_sec_reg    <= bcd_value(rec.hdr[4]);
            s1_dist10_reg <= {1'b0, raw_dist, 3'd0} + {3'd0, raw_dist, 1'b0};
            s1_temp_reg   <= rec.hdr[8];
            s1_ivl_reg    <= ivl;
            s1_index_reg  <= rec.index;
            s1_power_reg  <= {rec.smp[0][3:0], rec.smp[1]};
            s1_speed_reg  <= {rec.smp[0][5:4], rec.smp[2]};
            s1_cad_reg    <= rec.smp[3];
            s1_hr_reg     <= rec.last;
            s1_mark_reg   <= {rec.smp[0][7], rec.smp[0][6]};
        end
    end

    // Time of day, distance scaling and sample offset
    assign dist_prod = {{RECIP_W{1'b0}}, s1_dist10_reg} * {{DIST10_W{1'b0}}, DIST_RECIP};
    assign secs      = {12'd0, s1_hour_reg} * {6'd0, SECS_PER_HOUR}
                     + {10'd0, s1_min_reg} * {12'd0, SECS_PER_MIN}
                     + {10'd0, s1_sec_reg};
    assign offset    = {7'd0, s1_index_reg} * {3'd0, s1_ivl_reg};

    assign out_valid_next = adv_out ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            out_secs_reg   <= secs;
            out_dist_reg   <= dist_prod[DIST_SHIFT +: 23];
            out_offset_reg <= offset;
            out_day_reg    <= s1_day_reg;
            out_month_reg  <= s1_month_reg;
            out_temp_reg   <= s1_temp_reg;
            out_ivl_reg    <= s1_ivl_reg;
            out_power_reg  <= s1_power_reg;
            out_speed_reg  <= s1_speed_reg;
            out_cad_reg    <= s1_cad_reg;
            out_hr_reg     <= s1_hr_reg;
            out_mark_reg   <= s1_mark_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mark_reg, out_hr_reg, out_cad_reg, out_speed_reg,
                       out_power_reg, out_offset_reg, out_ivl_reg, out_temp_reg,
                       out_dist_reg, out_secs_reg, out_month_reg, out_day_reg};

endmodule

@@ rtl/ride_block_record_parser_top.sv @@
`timescale 1ns / 1ps
// Path: a result goes from the beat that takes the fifth byte of its sample through the
//   record queue, the decode stage and the output stage to m_tvalid; output stalls hold it.
// Throughput: one byte per cycle; s_tready drops only when the 4-entry record queue is full.
// Reset: aresetn is synchronous and active low; it clears block position, counters,
//   queue and pipeline valids. Header and sample byte registers are not reset.
module ride_block_record_parser_top #(
    parameter int SAMPLES_PER_BLOCK = 11
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] day, [10:6] month, [28:11] seconds_of_day, [51:29] distance_m,
    // [59:52] temperature, [67:60] interval_tenths, [78:68] offset_tenths,
    // [90:79] power, [100:91] speed_raw, [108:101] cadence, [116:109] heart_rate,
    // [118:117] marker_bits, [119] zero
    output logic [rbrp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rbrp_pkg::*;

    rbrp_push_t  push;
    rbrp_qstat_t qstat;
    rbrp_rec_t   pop_rec;
    logic        pop;

    rbrp_front #(
        .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .push     (push)
    );

    rbrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .qstat    (qstat)
    );

    rbrp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .rec      (pop_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/rbrp_checker.sv @@
`timescale 1ns / 1ps

module rbrp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rbrp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    // Nothing is left pending out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // An all-zero sample never produces a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[118:79] != 40'd0))
        else $error("result from an all-zero sample");

    // Decoded header fields and the offset stay in range, and bit 119 is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= 6'd45) && (m_tdata[10:6] <= 5'd25)
                  && (m_tdata[67:60] <= 8'd150) && (m_tdata[78:68] <= 11'd1500)
                  && !m_tdata[119])
        else $error("decoded field out of range");

endmodule

bind ride_block_record_parser_top rbrp_checker u_rbrp_checker (.*);

@@ sim/ride_block_record_parser_top_tb.sv @@
`timescale 1ns / 1ps

module ride_block_record_parser_top_tb;
    import rbrp_pkg::*;

    localparam int N_SAMPLES   = 11;
    localparam int BLOCK_BYTES = HEADER_LEN + SAMPLE_LEN * N_SAMPLES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 22;

    // One decoded sample record, laid out as on m_tdata (MSB first)
    typedef struct packed {
        logic              pad;
        logic [1:0]        marker_bits;
        logic [7:0]        heart_rate;
        logic [7:0]        cadence;
        logic [9:0]        speed_raw;
        logic [11:0]       power;
        logic [10:0]       offset_tenths;
        logic [7:0]        interval_tenths;
        logic signed [7:0] temperature;
        logic [22:0]       distance_m;
        logic [17:0]       seconds_of_day;
        logic [4:0]        month;
        logic [5:0]        day;
    } ride_rec_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'd0;  // [7:0] data_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // record fields, see ride_rec_t

    ride_block_record_parser_top #(
        .SAMPLES_PER_BLOCK(N_SAMPLES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock, 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Parser shadow state
    int         blk_pos;
    int         smp_idx;
    bit         blk_ended;
    logic [7:0] hdr_bytes[HEADER_LEN];
    logic [7:0] smp_bytes[4];

    ride_rec_t  pending_records[$];
    logic [7:0] blk[BLOCK_BYTES];

    int src_idle_pct = IDLE_PCT;
    int snk_stall_pct = IDLE_PCT;
    int fail_count;
    int bytes_sent;
    int blocks_sent;
    int records_checked;
    int zero_samples;
    int cycles;

    // Two BCD digits, no range check on the digits
    function automatic int digit_pair(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    // Advance the shadow parser by one byte; queue the record it yields, if any
    function automatic void predict_byte(input logic [7:0] b);
        int        k;
        int        ival;
        longint    raw;
        ride_rec_t r;
        if (blk_pos < HEADER_LEN) begin
            hdr_bytes[blk_pos] = b;
        end else begin
            k = blk_pos - HEADER_LEN - SAMPLE_LEN * smp_idx;
            if (k < 4) begin
                smp_bytes[k] = b;
            end else begin
                if (!blk_ended) begin
                    if ((smp_bytes[0] | smp_bytes[1] | smp_bytes[2] | smp_bytes[3] | b) == 8'd0)
                    begin
                        blk_ended = 1'b1;
                        zero_samples++;
                    end else begin
                        ival = {hdr_bytes[0][6], hdr_bytes[1][7:5]};
                        if (!hdr_bytes[2][6]) begin
                            ival = ival * 10;
                        end
                        raw = {hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
                        r.pad             = 1'b0;
                        r.day             = 6'(digit_pair(hdr_bytes[0] & 8'h3f));
                        r.month           = 5'(digit_pair(hdr_bytes[1] & 8'h1f));
                        r.seconds_of_day  = 18'(digit_pair(hdr_bytes[2] & 8'h3f) * 3600 +
                                                digit_pair(hdr_bytes[3]) * 60 +
                                                digit_pair(hdr_bytes[4]));
                        r.distance_m      = 23'(raw * 10 / 39);
                        r.temperature     = hdr_bytes[8];
                        r.interval_tenths = 8'(ival);
                        r.offset_tenths   = 11'(smp_idx * ival);
                        r.power           = {smp_bytes[0][3:0], smp_bytes[1]};
                        r.speed_raw       = {smp_bytes[0][5:4], smp_bytes[2]};
                        r.cadence         = smp_bytes[3];
                        r.heart_rate      = b;
                        r.marker_bits     = {smp_bytes[0][7], smp_bytes[0][6]};
                        pending_records.push_back(r);
                    end
                end
                smp_idx++;
            end
        end
        if (blk_pos == BLOCK_BYTES - 1) begin
            blk_pos   = 0;
            smp_idx   = 0;
            blk_ended = 1'b0;
        end else begin
            blk_pos++;
        end
    endfunction

    // Drive one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            send_byte(blk[i]);
        end
        blocks_sent++;
    endtask

    task automatic wait_drained();
        while (pending_records.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Header: half the time well-formed BCD, otherwise raw noise
    function automatic void random_header();
        bit bcd_ok;
        bcd_ok = $urandom_range(1);
        for (int i = 0; i < HEADER_LEN; i++) begin
            blk[i] = 8'($urandom);
        end
        if (bcd_ok) begin
            blk[0] = {1'b0, 1'($urandom), 2'($urandom_range(3)), 4'($urandom_range(9))};
            blk[1] = {3'($urandom), 1'($urandom_range(1)), 4'($urandom_range(9))};
            blk[2] = {1'b0, 1'($urandom), 2'($urandom_range(2)), 4'($urandom_range(9))};
            blk[3] = {4'($urandom_range(5)), 4'($urandom_range(9))};
            blk[4] = {4'($urandom_range(5)), 4'($urandom_range(9))};
        end
    endfunction

    // Sample j: mostly live data, some all-zero, some nearly zero
    function automatic void random_sample(input int j);
        int base;
        int kind;
        base = HEADER_LEN + SAMPLE_LEN * j;
        kind = $urandom_range(99);
        for (int i = 0; i < SAMPLE_LEN; i++) begin
            blk[base + i] = (kind < 85) ? 8'($urandom) : 8'd0;
        end
        if (kind >= 92) begin
            blk[base + $urandom_range(SAMPLE_LEN - 1)] = 8'(1 << $urandom_range(7));
        end
    endfunction

    function automatic void random_block();
        random_header();
        for (int j = 0; j < N_SAMPLES; j++) begin
            random_sample(j);
        end
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Output beat checker
    always @(posedge aclk) begin
        ride_rec_t got;
        ride_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_records.size() == 0) begin
                $error("unexpected output beat: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("day", want.day, got.day);
                check_field("month", want.month, got.month);
                check_field("seconds_of_day", want.seconds_of_day, got.seconds_of_day);
                check_field("distance_m", want.distance_m, got.distance_m);
                check_field("temperature", want.temperature, got.temperature);
                check_field("interval_tenths", want.interval_tenths, got.interval_tenths);
                check_field("offset_tenths", want.offset_tenths, got.offset_tenths);
                check_field("power", want.power, got.power);
                check_field("speed_raw", want.speed_raw, got.speed_raw);
                check_field("cadence", want.cadence, got.cadence);
                check_field("heart_rate", want.heart_rate, got.heart_rate);
                check_field("marker_bits", want.marker_bits, got.marker_bits);
                records_checked++;
            end
        end
    end

    // Output side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // All fields at their top: invalid BCD digits, long interval, max distance,
    // coldest temperature, then corner samples out to the last slot
    task automatic test_extreme_header();
        int base;
        blk[0] = 8'hff;
        blk[1] = 8'hff;
        blk[2] = 8'h3f;
        blk[3] = 8'hff;
        blk[4] = 8'hff;
        blk[5] = 8'hff;
        blk[6] = 8'hff;
        blk[7] = 8'hff;
        blk[8] = 8'h80;
        for (int j = 0; j < N_SAMPLES; j++) begin
            random_sample(j);
            base = HEADER_LEN + SAMPLE_LEN * j;
            blk[base + 4] = 8'($urandom_range(255, 1));
        end
        // all ones, heart rate only, new marker only, continue marker only
        for (int i = 0; i < SAMPLE_LEN; i++) begin
            blk[HEADER_LEN + i] = 8'hff;
            blk[HEADER_LEN + SAMPLE_LEN + i] = 8'h00;
            blk[HEADER_LEN + 2 * SAMPLE_LEN + i] = 8'h00;
            blk[HEADER_LEN + 3 * SAMPLE_LEN + i] = 8'h00;
        end
        blk[HEADER_LEN + SAMPLE_LEN + 4] = 8'h01;
        blk[HEADER_LEN + 2 * SAMPLE_LEN] = 8'h40;
        blk[HEADER_LEN + 3 * SAMPLE_LEN] = 8'h80;
        send_block();
    endtask

    // Sub-second interval; an all-zero second sample ends the block early,
    // and the next block must start clean
    task automatic test_zero_sample();
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            blk[i] = 8'($urandom_range(255, 1));
        end
        blk[0] = 8'h40;
        blk[1] = 8'h20;
        blk[2] = 8'h63;
        blk[5] = 8'h00;
        blk[6] = 8'h00;
        blk[7] = 8'h00;
        blk[8] = 8'h7f;
        for (int i = 0; i < SAMPLE_LEN; i++) begin
            blk[HEADER_LEN + SAMPLE_LEN + i] = 8'h00;
        end
        send_block();
        random_block();
        send_block();
    endtask

    task automatic test_random_blocks(input int n);
        for (int b = 0; b < n; b++) begin
            random_block();
            send_block();
        end
    endtask

    // Both sides run flat out
    task automatic test_full_rate(input int n);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        test_random_blocks(n);
        src_idle_pct  = IDLE_PCT;
        snk_stall_pct = IDLE_PCT;
    endtask

    // Sender holds off until every pending record is out
    task automatic test_drain_pause(input int n);
        for (int b = 0; b < n; b++) begin
            random_block();
            send_block();
            s_tvalid <= 1'b0;
            wait_drained();
            // the bus idles before the next beat is driven
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_header();
        test_zero_sample();
        test_random_blocks(10);
        test_full_rate(5);
        test_drain_pause(2);
        test_random_blocks(5);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("tb: %0d bytes in %0d blocks, %0d records checked, %0d zero samples",
                 bytes_sent, blocks_sent, records_checked, zero_samples);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
